[rtl/core/olist_pkg.sv]
// Shared types, codes and defaults for the ordered list engine.
`timescale 1ns / 1ps

package olist_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int POS_BITS       = 6;
    localparam int CMD_BITS       = 3;
    localparam int STATUS_BITS    = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD_FRONT    = 3'd0,
        CMD_ADD_BACK     = 3'd1,
        CMD_INSERT_AT    = 3'd2,
        CMD_REMOVE_AT    = 3'd3,
        CMD_REMOVE_FRONT = 3'd4,
        CMD_REMOVE_BACK  = 3'd5,
        CMD_READ         = 3'd6,
        CMD_CONTAINS     = 3'd7
    } t_command;

    localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

    // Work the datapath sets up when a request is loaded.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_OPEN_FRONT,
        OP_APPEND,
        OP_OPEN_AT,
        OP_CLOSE_AT,
        OP_CLOSE_FRONT,
        OP_CLOSE_BACK,
        OP_READ,
        OP_SEARCH
    } t_op;

    typedef enum logic [1:0] {
        DS_ZERO,
        DS_WORD,
        DS_ONES
    } t_dsel;

    typedef struct packed {
        logic                   load;
        t_op                    op;
        logic                   step;
        logic                   commit;
        logic [STATUS_BITS-1:0] st;
        t_dsel                  dsel;
        logic                   add;
        logic                   sub;
    } t_ctl_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_in;
        logic busy;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/core/ordered_list_engine_core.sv]
// Top level of the ordered list engine: controller and datapath joined.
//
//   Channel  | Handshake                | Payload
//   request  | i_in_valid / o_in_ready  | i_command, i_value, i_position
//   result   | o_out_valid / i_out_ready| o_status, o_data, o_found, o_count
//
// Each request passes through the idle, run and finish states; in the run state
// the datapath moves or reads the entries the request touches: a front add moves
// every entry, a positional insert moves count-position entries, a remove moves the
// entries behind it, a membership test reads every stored entry, a read one entry.
// The entry store has a single read and a single write port.
// Reset is synchronous and active low; it empties the list, the store itself
// is not cleared. A held result stalls only the final commit of the next request.
`timescale 1ns / 1ps

module ordered_list_engine_core
    import olist_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CNT_BITS  = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic        [CMD_BITS-1:0]    i_command,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    input  logic        [POS_BITS-1:0]    i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic        [STATUS_BITS-1:0] o_status,
    output logic signed [VALUE_BITS-1:0]  o_data,
    output logic                          o_found,
    output logic        [CNT_BITS-1:0]    o_count
);

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_stat;

    olist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_stat     (dp_stat),
        .o_cmd      (ctl_cmd)
    );

    olist_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_stat      (dp_stat),
        .i_value     (i_value),
        .i_position  (i_position),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_found     (o_found),
        .o_count     (o_count)
    );

endmodule

[rtl/core/olist_dp.sv]
// Datapath of the ordered list engine: entry store, shift and scan sequencing, result register.
`timescale 1ns / 1ps

module olist_dp
    import olist_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CNT_BITS  = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl_cmd                     i_cmd,
    output t_dp_status                   o_stat,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic        [POS_BITS-1:0]   i_position,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic        [STATUS_BITS-1:0] o_status,
    output logic signed [VALUE_BITS-1:0] o_data,
    output logic                         o_found,
    output logic        [CNT_BITS-1:0]   o_count
);

    localparam int AW       = $clog2(DEPTH);
    localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [VALUE_BITS-1:0] r_val;
    logic [CNT_BITS-1:0]   r_at, n_at;
    logic [CNT_BITS-1:0]   r_ptr, n_ptr;
    logic [CNT_BITS-1:0]   r_left, n_left;
    logic                  r_down, n_down;
    logic                  r_move, n_move;
    logic                  r_search, n_search;
    logic                  r_found;
    logic                  r_pv;
    logic [AW-1:0]         r_pa;
    logic [VALUE_BITS-1:0] r_rd;

    logic                  r_o_valid;
    logic [STATUS_BITS-1:0] r_o_status;
    logic [VALUE_BITS-1:0] r_o_data;
    logic                  r_o_found;
    logic [CNT_BITS-1:0]   r_o_count;

    logic [CNT_BITS-1:0]   pos_c;
    logic                  rd_en;
    logic                  we;
    logic [AW-1:0]         wa;
    logic [VALUE_BITS-1:0] wd;

    assign pos_c = CNT_BITS'(i_position);
    assign rd_en = i_cmd.step && (r_left != '0);

    assign o_stat.full     = (r_count == CNT_BITS'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.pos_in   = (CMP_BITS'(i_position) < CMP_BITS'(r_count));
    assign o_stat.busy     = (r_left != '0) || r_pv;
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    // Set up the walk over the store for the request being loaded.
    always_comb begin
        n_at     = r_at;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_down   = r_down;
        n_move   = r_move;
        n_search = r_search;
        if (i_cmd.load) begin
            n_at     = '0;
            n_ptr    = '0;
            n_left   = '0;
            n_down   = 1'b0;
            n_move   = 1'b0;
            n_search = 1'b0;
            case (i_cmd.op)
                OP_OPEN_FRONT: begin
                    n_ptr  = r_count - 1'b1;
                    n_left = r_count;
                    n_down = 1'b1;
                    n_move = 1'b1;
                end
                OP_APPEND: begin
                    n_at = r_count;
                end
                OP_OPEN_AT: begin
                    n_at   = pos_c;
                    n_ptr  = r_count - 1'b1;
                    n_left = r_count - pos_c;
                    n_down = 1'b1;
                    n_move = 1'b1;
                end
                OP_CLOSE_AT: begin
                    n_at   = pos_c;
                    n_ptr  = pos_c + 1'b1;
                    n_left = r_count - pos_c - 1'b1;
                    n_move = 1'b1;
                end
                OP_CLOSE_FRONT: begin
                    n_ptr  = CNT_BITS'(1);
                    n_left = r_count - 1'b1;
                    n_move = 1'b1;
                end
                OP_CLOSE_BACK: begin
                    n_at = r_count - 1'b1;
                end
                OP_READ: begin
                    n_ptr  = pos_c;
                    n_left = CNT_BITS'(1);
                end
                OP_SEARCH: begin
                    n_left   = r_count;
                    n_search = 1'b1;
                end
                default: begin
                    n_left = '0;
                end
            endcase
        end else if (rd_en) begin
            n_ptr  = r_down ? (r_ptr - 1'b1) : (r_ptr + 1'b1);
            n_left = r_left - 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.commit && i_cmd.add) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.commit && i_cmd.sub) begin
            n_count = r_count - 1'b1;
        end
    end

    // One write port: shifted words while stepping, the new word at commit.
    always_comb begin
        we = 1'b0;
        wa = r_pa;
        wd = r_rd;
        if (i_cmd.step && r_pv && r_move) begin
            we = 1'b1;
            wa = r_down ? AW'(r_pa + 1'b1) : AW'(r_pa - 1'b1);
        end else if (i_cmd.commit && i_cmd.add) begin
            we = 1'b1;
            wa = r_at[AW-1:0];
            wd = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd <= mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_left    <= '0;
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
            r_pv    <= rd_en;
            if (i_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_at     <= n_at;
        r_ptr    <= n_ptr;
        r_down   <= n_down;
        r_move   <= n_move;
        r_search <= n_search;
        if (rd_en) begin
            r_pa <= r_ptr[AW-1:0];
        end
        if (i_cmd.load) begin
            r_val   <= i_value;
            r_found <= 1'b0;
        end else if (i_cmd.step && r_pv && r_search && (r_rd == r_val)) begin
            r_found <= 1'b1;
        end
        if (i_cmd.commit) begin
            r_o_status <= i_cmd.st;
            r_o_found  <= r_found;
            r_o_count  <= n_count;
            case (i_cmd.dsel)
                DS_WORD: r_o_data <= r_rd;
                DS_ONES: r_o_data <= '1;
                default: r_o_data <= '0;
            endcase
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_data      = r_o_data;
    assign o_found     = r_o_found;
    assign o_count     = r_o_count;

endmodule

[rtl/core/olist_ctrl.sv]
// Controller of the ordered list engine: decodes each request and sequences the datapath.
`timescale 1ns / 1ps

module olist_ctrl
    import olist_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_BITS-1:0] i_command,
    input  t_dp_status          i_stat,
    output t_ctl_cmd            o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    t_state                 r_state, n_state;
    logic [STATUS_BITS-1:0] r_st, n_st;
    t_dsel                  r_dsel, n_dsel;
    logic                   r_add, n_add;
    logic                   r_sub, n_sub;
    t_op                    dec_op;
    logic                   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // Decide what the request does from the current count and position.
    always_comb begin
        dec_op = OP_NONE;
        n_st   = ST_DONE;
        n_dsel = DS_ZERO;
        n_add  = 1'b0;
        n_sub  = 1'b0;
        case (t_command'(i_command))
            CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT_AT: begin
                if (i_stat.full) begin
                    n_st = ST_FULL;
                end else if (t_command'(i_command) == CMD_ADD_FRONT || i_stat.empty) begin
                    dec_op = OP_OPEN_FRONT;
                    n_add  = 1'b1;
                end else if (t_command'(i_command) == CMD_ADD_BACK) begin
                    dec_op = OP_APPEND;
                    n_add  = 1'b1;
                end else if (!i_stat.pos_in) begin
                    n_st = ST_IGNORED;
                end else begin
                    dec_op = OP_OPEN_AT;
                    n_add  = 1'b1;
                end
            end
            CMD_REMOVE_AT: begin
                if (i_stat.pos_in) begin
                    dec_op = OP_CLOSE_AT;
                    n_sub  = 1'b1;
                end else begin
                    n_st = ST_IGNORED;
                end
            end
            CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
                if (i_stat.empty) begin
                    n_st = ST_IGNORED;
                end else begin
                    dec_op = (t_command'(i_command) == CMD_REMOVE_FRONT) ? OP_CLOSE_FRONT
                                                                        : OP_CLOSE_BACK;
                    n_sub  = 1'b1;
                end
            end
            CMD_READ: begin
                if (i_stat.pos_in) begin
                    dec_op = OP_READ;
                    n_dsel = DS_WORD;
                end else begin
                    n_st   = ST_IGNORED;
                    n_dsel = DS_ONES;
                end
            end
            CMD_CONTAINS: begin
                dec_op = OP_SEARCH;
            end
            default: begin
                dec_op = OP_NONE;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_stat.busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_DONE;
            r_dsel  <= DS_ZERO;
            r_add   <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_st   <= n_st;
                r_dsel <= n_dsel;
                r_add  <= n_add;
                r_sub  <= n_sub;
            end
        end
    end

    assign o_cmd.load   = accept;
    assign o_cmd.op     = dec_op;
    assign o_cmd.step   = (r_state == S_RUN);
    assign o_cmd.commit = (r_state == S_FIN) && i_stat.out_free;
    assign o_cmd.st     = r_st;
    assign o_cmd.dsel   = r_dsel;
    assign o_cmd.add    = r_add;
    assign o_cmd.sub    = r_sub;

endmodule

[sim/ordered_list_engine_core_tb.sv]
// Testbench for the ordered list engine: directed table, shaped random traffic, scoreboard.
`timescale 1ns / 1ps

module ordered_list_engine_core_tb;
    import olist_pkg::*;

    localparam int LIST_DEPTH     = DEPTH_DEF;
    localparam int WORD_BITS      = VALUE_BITS_DEF;
    localparam int COUNT_BITS     = $clog2(DEPTH_DEF + 1);
    localparam int RANDOM_ITEMS   = 1000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [WORD_BITS-1:0]   data;
        logic                   found;
        logic [COUNT_BITS-1:0]  count;
    } t_result;

    typedef struct packed {
        t_command              cmd;
        logic [WORD_BITS-1:0]  value;
        logic [POS_BITS-1:0]   pos;
        logic                  typed;
        t_result               want;
    } t_step;

    typedef enum {
        TRAFFIC_GROW,
        TRAFFIC_SHRINK,
        TRAFFIC_CHURN
    } t_traffic;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic        [CMD_BITS-1:0]    i_command    = CMD_ADD_FRONT;
    logic signed [WORD_BITS-1:0]   i_value      = '0;
    logic        [POS_BITS-1:0]    i_position   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic        [STATUS_BITS-1:0] o_status;
    logic signed [WORD_BITS-1:0]   o_data;
    logic                          o_found;
    logic        [COUNT_BITS-1:0]  o_count;

    logic [WORD_BITS-1:0] stored_words[$];
    t_result              pending_results[$];
    t_step                request_table[23];
    int                   sender_idle_pct  = 26;
    int                   result_stall_pct = 76;
    int                   mismatch_count   = 0;
    int                   results_seen     = 0;
    int                   quiet_cycles     = 0;

    ordered_list_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_position (i_position),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_found    (o_found),
        .o_count    (o_count)
    );

    always #10 i_clk = ~i_clk;

    // Applies one request to the list held here and gives the result it must produce.
    function automatic t_result apply_request(t_command cmd, logic [WORD_BITS-1:0] value,
                                              logic [POS_BITS-1:0] pos);
        t_result r;
        int      n;
        r.status = ST_DONE;
        r.data   = '0;
        r.found  = 1'b0;
        n = stored_words.size();
        case (cmd)
            CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT_AT: begin
                // A full list refuses before the position is looked at.
                if (n >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (cmd == CMD_ADD_FRONT || n == 0) begin
                    stored_words.push_front(value);
                end else if (cmd == CMD_ADD_BACK) begin
                    stored_words.push_back(value);
                end else if (pos >= n) begin
                    r.status = ST_IGNORED;
                end else begin
                    stored_words.insert(pos, value);
                end
            end
            CMD_REMOVE_AT, CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
                if (n == 0 || (cmd == CMD_REMOVE_AT && pos >= n)) begin
                    r.status = ST_IGNORED;
                end else if (cmd == CMD_REMOVE_FRONT) begin
                    void'(stored_words.pop_front());
                end else if (cmd == CMD_REMOVE_BACK) begin
                    void'(stored_words.pop_back());
                end else begin
                    stored_words.delete(pos);
                end
            end
            CMD_READ: begin
                if (pos < n) begin
                    r.data = stored_words[pos];
                end else begin
                    r.data   = '1;
                    r.status = ST_IGNORED;
                end
            end
            default: begin
                foreach (stored_words[k]) begin
                    if (stored_words[k] == value) r.found = 1'b1;
                end
            end
        endcase
        r.count = COUNT_BITS'(stored_words.size());
        return r;
    endfunction

    // Random request shaped by the traffic mode, with a little pure noise mixed in.
    function automatic t_step make_request(t_traffic mode);
        t_step s;
        int    n;
        int    roll;
        int    group;
        n = stored_words.size();
        s = '0;
        if ($urandom_range(99) < 5) begin
            s.cmd   = t_command'($urandom_range(int'(CMD_CONTAINS), int'(CMD_ADD_FRONT)));
            s.value = $urandom;
            s.pos   = POS_BITS'($urandom_range(63));
            return s;
        end
        roll = $urandom_range(99);
        case (mode)
            TRAFFIC_GROW:   group = (roll < 80) ? 0 : (roll < 90) ? 1 : 2;
            TRAFFIC_SHRINK: group = (roll < 80) ? 1 : (roll < 90) ? 0 : 2;
            default:        group = (roll < 35) ? 0 : (roll < 65) ? 1 : 2;
        endcase
        case (group)
            0: s.cmd = t_command'($urandom_range(int'(CMD_INSERT_AT), int'(CMD_ADD_FRONT)));
            1: s.cmd = t_command'($urandom_range(int'(CMD_REMOVE_BACK), int'(CMD_REMOVE_AT)));
            default: s.cmd = t_command'($urandom_range(int'(CMD_CONTAINS), int'(CMD_READ)));
        endcase
        case ($urandom_range(9))
            0: s.pos = '0;
            1: s.pos = (n > 0) ? POS_BITS'(n - 1) : '0;
            2: s.pos = (n > 63) ? POS_BITS'(63) : POS_BITS'(n);
            3: s.pos = '1;
            4: s.pos = POS_BITS'($urandom_range(63));
            default: s.pos = (n > 0) ? POS_BITS'($urandom_range(n - 1))
                                     : POS_BITS'($urandom_range(63));
        endcase
        case ($urandom_range(9))
            0: s.value = 32'h7FFF_FFFF;
            1: s.value = 32'h8000_0000;
            2: s.value = '1;
            3: s.value = '0;
            4, 5, 6: s.value = (n > 0) ? stored_words[$urandom_range(n - 1)] : $urandom;
            default: s.value = $urandom;
        endcase
        return s;
    endfunction

    task automatic send_request(input t_step s);
        t_result predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= s.cmd;
        i_value    <= s.value;
        i_position <= s.pos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // The list held here is always updated, even where the row carries its own answer.
        predicted = apply_request(s.cmd, s.value, s.pos);
        pending_results.push_back(s.typed ? s.want : predicted);
    endtask

    initial begin
        t_traffic mode;
        request_table[0]  = '{CMD_READ, 32'h0, 6'd0, 1'b1, '{ST_IGNORED, '1, 1'b0, 7'd0}};
        request_table[1]  = '{CMD_REMOVE_FRONT, 32'h0, 6'd0, 1'b1, '{ST_IGNORED, '0, 1'b0, 7'd0}};
        request_table[2]  = '{CMD_REMOVE_BACK, 32'h0, 6'd0, 1'b1, '{ST_IGNORED, '0, 1'b0, 7'd0}};
        request_table[3]  = '{CMD_REMOVE_AT, 32'h0, 6'd0, 1'b1, '{ST_IGNORED, '0, 1'b0, 7'd0}};
        request_table[4]  = '{CMD_CONTAINS, 32'h0, 6'd0, 1'b1, '{ST_DONE, '0, 1'b0, 7'd0}};
        request_table[5]  = '{CMD_INSERT_AT, 32'h7FFF_FFFF, 6'd63, 1'b1,
                              '{ST_DONE, '0, 1'b0, 7'd1}};
        request_table[6]  = '{CMD_ADD_FRONT, 32'h8000_0000, 6'd0, 1'b1,
                              '{ST_DONE, '0, 1'b0, 7'd2}};
        request_table[7]  = '{CMD_ADD_BACK, 32'hFFFF_FFFF, 6'd0, 1'b1, '{ST_DONE, '0, 1'b0, 7'd3}};
        // Insert at the last position must land before the last entry.
        request_table[8]  = '{CMD_INSERT_AT, 32'h5, 6'd2, 1'b0, '0};
        request_table[9]  = '{CMD_INSERT_AT, 32'h7, 6'd4, 1'b1, '{ST_IGNORED, '0, 1'b0, 7'd4}};
        request_table[10] = '{CMD_INSERT_AT, 32'h7, 6'd63, 1'b1, '{ST_IGNORED, '0, 1'b0, 7'd4}};
        request_table[11] = '{CMD_READ, 32'h0, 6'd2, 1'b0, '0};
        request_table[12] = '{CMD_READ, 32'h0, 6'd3, 1'b0, '0};
        request_table[13] = '{CMD_READ, 32'h0, 6'd4, 1'b1, '{ST_IGNORED, '1, 1'b0, 7'd4}};
        request_table[14] = '{CMD_READ, 32'hA5A5_A5A5, 6'd63, 1'b1,
                              '{ST_IGNORED, '1, 1'b0, 7'd4}};
        request_table[15] = '{CMD_CONTAINS, 32'h8000_0000, 6'd0, 1'b0, '0};
        request_table[16] = '{CMD_CONTAINS, 32'h0000_3039, 6'd0, 1'b0, '0};
        request_table[17] = '{CMD_REMOVE_AT, 32'h0, 6'd4, 1'b1, '{ST_IGNORED, '0, 1'b0, 7'd4}};
        request_table[18] = '{CMD_REMOVE_AT, 32'h0, 6'd1, 1'b0, '0};
        request_table[19] = '{CMD_REMOVE_FRONT, 32'h0, 6'd0, 1'b0, '0};
        request_table[20] = '{CMD_REMOVE_BACK, 32'h0, 6'd0, 1'b0, '0};
        request_table[21] = '{CMD_INSERT_AT, 32'h5555_5555, 6'd0, 1'b0, '0};
        request_table[22] = '{CMD_READ, 32'h0, 6'd0, 1'b0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (request_table[k]) send_request(request_table[k]);

        mode = TRAFFIC_GROW;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                sender_idle_pct  = 76;
                result_stall_pct = 26;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct  = 0;
                result_stall_pct = 0;
            end
            // Long stretches of one kind of traffic drive the list to full and back to empty.
            if (n % 64 == 0) mode = t_traffic'($urandom_range(2));
            send_request(make_request(mode));
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random back-pressure and the scoreboard check.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < REPORT_LIMIT)
                        $display("result %0d arrived with no request outstanding", results_seen);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status || o_data !== want.data ||
                        o_found !== want.found || o_count !== want.count) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < REPORT_LIMIT)
                            $display({"result %0d: expected status %0d data %0d found %0d ",
                                      "count %0d, got status %0d data %0d found %0d count %0d"},
                                     results_seen, want.status, $signed(want.data),
                                     want.found, want.count, o_status, o_data, o_found,
                                     o_count);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= result_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
